/* rtl/gat_pkg.sv */
// Shared types, codes and constants for the gate actuator supervisor.
`timescale 1ns / 1ps
`default_nettype none
package gat_pkg;

    // Number of gates whose state is kept; range 1 to 32.
    localparam int NUM_GATES = 10;
    // Gates that have switch inputs and appear in the result fields.
    localparam int IO_GATES = 10;
    localparam int IDX_W = (NUM_GATES > 1) ? $clog2(NUM_GATES) : 1;
    // The active count never exceeds what the 4-bit gate_count can hold.
    localparam int ACTIVE_CAP = (NUM_GATES > 15) ? 15 : NUM_GATES;
    localparam int STATES_W = 3 * IO_GATES;

    localparam logic [3:0] GATE_COUNT_RESET = 4'd10;
    localparam logic [15:0] MOVE_TIMEOUT_RESET = 16'd10000;
    localparam logic [1:0] RETRY_LIMIT_RESET = 2'd3;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_OPENING = 3'd1,
        MODE_CLOSING = 3'd2,
        MODE_OPEN = 3'd3,
        MODE_CLOSED = 3'd4,
        MODE_ERROR = 3'd5
    } gate_mode_t;

    typedef enum logic [1:0] {
        CMD_SWEEP = 2'd0,
        CMD_OPEN = 2'd1,
        CMD_CLOSE = 2'd2,
        CMD_QUERY = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        SENSE_UNKNOWN = 2'd0,
        SENSE_OPEN = 2'd1,
        SENSE_CLOSED = 2'd2
    } sense_t;

    typedef enum logic [1:0] {
        CFG_GATE_COUNT = 2'd0,
        CFG_MOVE_TIMEOUT = 2'd1,
        CFG_RETRY_LIMIT = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_PUBLISH
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic publish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_sweep;
        logic sweep_empty;
        logic last;
    } dp_status_t;

endpackage
`default_nettype wire

/* rtl/gat_ctrl.sv */
// Controller state machine that sequences load, per-gate steps and publish.
`timescale 1ns / 1ps
`default_nettype none
module gat_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire gat_pkg::dp_status_t status,
    output gat_pkg::ctrl_cmd_t      ctrl,
    output logic                    busy
);
    import gat_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                // A single command takes one step; a sweep ends on its last gate, or at once when no gate is active.
                if (!status.is_sweep || status.sweep_empty || status.last)
                begin
                    state_next = ST_PUBLISH;
                end
            end
            ST_PUBLISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                ctrl.load = start;
            end
            ST_STEP:
            begin
                ctrl.step = !(status.is_sweep && status.sweep_empty);
            end
            ST_PUBLISH:
            begin
                ctrl.publish = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/gat_datapath.sv */
// Datapath: configuration, per-gate state registers, step logic and result registers.
`timescale 1ns / 1ps
`default_nettype none
module gat_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire gat_pkg::ctrl_cmd_t            ctrl,
    output gat_pkg::dp_status_t                status,
    input  wire logic                          cfg_valid,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [15:0]                   cfg_data,
    input  wire logic [1:0]                    command,
    input  wire logic [3:0]                    gate_number,
    input  wire logic [31:0]                   now_ms,
    input  wire logic [gat_pkg::IO_GATES-1:0]  open_switch_levels,
    input  wire logic [gat_pkg::IO_GATES-1:0]  closed_switch_levels,
    output logic                               result_valid,
    output logic [gat_pkg::STATES_W-1:0]       gate_states,
    output logic [gat_pkg::IO_GATES-1:0]       drive_mask,
    output logic [gat_pkg::IO_GATES-1:0]       drive_toward_open,
    output logic [1:0]                         sensed_position
);
    import gat_pkg::*;

    logic [3:0] gate_count_reg;
    logic [15:0] move_timeout_reg;
    logic [1:0] retry_limit_reg;

    gate_mode_t mode_reg [NUM_GATES];
    logic [31:0] start_reg [NUM_GATES];
    logic [1:0] retry_reg [NUM_GATES];

    cmd_t cmd_reg;
    logic [3:0] num_reg;
    logic [31:0] now_reg;
    logic [IO_GATES-1:0] open_lv_reg;
    logic [IO_GATES-1:0] closed_lv_reg;
    logic [3:0] idx_reg;
    logic [IO_GATES-1:0] mask_reg;
    logic [IO_GATES-1:0] dir_reg;
    sense_t sensed_reg;
    logic valid_reg;
    logic [STATES_W-1:0] states_reg;

    logic [3:0] active;
    logic in_range;
    logic [3:0] gate_idx;
    logic [3:0] sel;
    logic [IDX_W-1:0] sel_idx;
    logic sel_io;
    gate_mode_t cur_mode;
    logic [31:0] cur_start;
    logic [1:0] cur_retry;
    logic [31:0] elapsed;
    logic timed_out;
    logic open_hit;
    logic closed_hit;
    gate_mode_t mode_next;
    logic [31:0] start_next;
    logic [1:0] retry_next;
    logic drive;
    logic toward;
    sense_t sensed_next;
    logic [IO_GATES-1:0] mask_next;
    logic [IO_GATES-1:0] dir_next;
    logic [STATES_W-1:0] states_w;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_count_reg <= GATE_COUNT_RESET;
            move_timeout_reg <= MOVE_TIMEOUT_RESET;
            retry_limit_reg <= RETRY_LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GATE_COUNT: gate_count_reg <= cfg_data[3:0];
                CFG_MOVE_TIMEOUT: move_timeout_reg <= cfg_data;
                CFG_RETRY_LIMIT: retry_limit_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign active = (gate_count_reg < 4'(ACTIVE_CAP)) ? gate_count_reg : 4'(ACTIVE_CAP);
    assign in_range = (num_reg != 4'd0) && (num_reg <= active);
    assign gate_idx = in_range ? 4'(num_reg - 4'd1) : 4'd0;

    assign status.is_sweep = (cmd_reg == CMD_SWEEP);
    assign status.sweep_empty = (active == 4'd0);
    assign status.last = (4'(idx_reg + 4'd1) == active);

    // Everything below works on one gate: the sweep position or the addressed gate.
    assign sel = (cmd_reg == CMD_SWEEP) ? idx_reg : gate_idx;
    assign sel_idx = IDX_W'(sel);
    assign sel_io = (sel < 4'(IO_GATES));
    assign cur_mode = mode_reg[sel_idx];
    assign cur_start = start_reg[sel_idx];
    assign cur_retry = retry_reg[sel_idx];
    assign elapsed = now_reg - cur_start;
    assign timed_out = elapsed > {16'd0, move_timeout_reg};
    assign open_hit = sel_io && !open_lv_reg[sel];
    assign closed_hit = sel_io && !closed_lv_reg[sel];

    always_comb
    begin
        mode_next = cur_mode;
        start_next = cur_start;
        retry_next = cur_retry;
        drive = 1'b0;
        toward = 1'b0;
        sensed_next = sensed_reg;
        unique case (cmd_reg)
            CMD_SWEEP:
            begin
                if (cur_mode == MODE_OPENING || cur_mode == MODE_CLOSING)
                begin
                    priority if (timed_out)
                    begin
                        if (cur_retry < retry_limit_reg)
                        begin
                            retry_next = 2'(cur_retry + 2'd1);
                            start_next = now_reg;
                            drive = 1'b1;
                            toward = (cur_mode == MODE_OPENING);
                        end
                        else
                        begin
                            mode_next = MODE_ERROR;
                        end
                    end
                    else if (cur_mode == MODE_OPENING && open_hit)
                    begin
                        mode_next = MODE_OPEN;
                    end
                    else if (cur_mode == MODE_CLOSING && closed_hit)
                    begin
                        mode_next = MODE_CLOSED;
                    end
                    else
                    begin
                        // Still moving within its time: nothing changes.
                        mode_next = cur_mode;
                    end
                end
            end
            CMD_OPEN:
            begin
                if (in_range && (cur_mode == MODE_CLOSED || cur_mode == MODE_ERROR))
                begin
                    mode_next = MODE_OPENING;
                    start_next = now_reg;
                    retry_next = 2'd0;
                    drive = 1'b1;
                    toward = 1'b1;
                end
            end
            CMD_CLOSE:
            begin
                if (in_range && (cur_mode == MODE_OPEN || cur_mode == MODE_ERROR))
                begin
                    mode_next = MODE_CLOSING;
                    start_next = now_reg;
                    retry_next = 2'd0;
                    drive = 1'b1;
                end
            end
            CMD_QUERY:
            begin
                if (in_range)
                begin
                    priority if (open_hit)
                    begin
                        sensed_next = SENSE_OPEN;
                    end
                    else if (closed_hit)
                    begin
                        sensed_next = SENSE_CLOSED;
                    end
                    else
                    begin
                        sensed_next = sensed_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        mask_next = mask_reg;
        dir_next = dir_reg;
        if (drive && sel_io)
        begin
            mask_next[sel] = 1'b1;
            dir_next[sel] = toward;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_GATES; i++)
            begin
                mode_reg[i] <= MODE_CLOSED;
            end
        end
        else if (ctrl.step)
        begin
            mode_reg[sel_idx] <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            start_reg[sel_idx] <= start_next;
            retry_reg[sel_idx] <= retry_next;
        end
    end

    // Item capture and per-item accumulators.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= cmd_t'(command);
            num_reg <= gate_number;
            now_reg <= now_ms;
            open_lv_reg <= open_switch_levels;
            closed_lv_reg <= closed_switch_levels;
            idx_reg <= 4'd0;
            mask_reg <= '0;
            dir_reg <= '0;
            sensed_reg <= SENSE_UNKNOWN;
        end
        else if (ctrl.step)
        begin
            idx_reg <= 4'(idx_reg + 4'd1);
            mask_reg <= mask_next;
            dir_reg <= dir_next;
            sensed_reg <= sensed_next;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < IO_GATES; gi++)
        begin : g_states
            if (gi < NUM_GATES)
            begin : g_kept
                assign states_w[3*gi +: 3] = mode_reg[gi];
            end
            else
            begin : g_absent
                assign states_w[3*gi +: 3] = 3'd0;
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (ctrl.publish)
        begin
            states_reg <= states_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= ctrl.publish;
        end
    end

    assign result_valid = valid_reg;
    assign gate_states = states_reg;
    assign drive_mask = mask_reg;
    assign drive_toward_open = dir_reg;
    assign sensed_position = sensed_reg;

endmodule
`default_nettype wire

/* rtl/gate_actuator_timeout_retry_fsm.sv */
// Top level of the gate actuator supervisor with move timeout and retry.
// An item is taken when start is high and busy is low. A query, open or close
// command takes a single step, then the controller passes through publish to the
// registered result strobe; a service sweep steps through the active gates one per
// cycle in the per-gate state registers before it publishes its result, and busy
// falls in the strobe cycle so the next item can be taken there. result_valid is
// high for exactly one cycle; gate_states holds until the next result, while
// drive_mask, drive_toward_open and sensed_position are valid only in the strobe
// cycle. The receiver cannot stall. Configuration writes are always ready and
// must be issued only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module gate_actuator_timeout_retry_fsm (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    command,
    input  wire logic [3:0]                    gate_number,
    input  wire logic [31:0]                   now_ms,
    input  wire logic [gat_pkg::IO_GATES-1:0]  open_switch_levels,
    input  wire logic [gat_pkg::IO_GATES-1:0]  closed_switch_levels,
    output logic                               result_valid,
    output logic [gat_pkg::STATES_W-1:0]       gate_states,
    output logic [gat_pkg::IO_GATES-1:0]       drive_mask,
    output logic [gat_pkg::IO_GATES-1:0]       drive_toward_open,
    output logic [1:0]                         sensed_position,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [15:0]                   cfg_data
);
    import gat_pkg::*;

    ctrl_cmd_t ctrl;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    gat_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    gat_datapath u_datapath (
        .clk                  (clk),
        .rst_n                (rst_n),
        .ctrl                 (ctrl),
        .status               (status),
        .cfg_valid            (cfg_valid),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .command              (command),
        .gate_number          (gate_number),
        .now_ms               (now_ms),
        .open_switch_levels   (open_switch_levels),
        .closed_switch_levels (closed_switch_levels),
        .result_valid         (result_valid),
        .gate_states          (gate_states),
        .drive_mask           (drive_mask),
        .drive_toward_open    (drive_toward_open),
        .sensed_position      (sensed_position)
    );

`ifndef NO_ASSERTIONS
    // The result strobe falls in the cycle where the controller is back to idle.
    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result strobe while busy");

    // An accepted item always starts work in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // One result per item: strobes never come in adjacent cycles.
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe lasted more than one cycle");

    // A drive direction is only reported for a driven gate.
    a_dir_in_mask: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((drive_toward_open & ~drive_mask) == '0))
        else $error("drive direction set for a gate that is not driven");
`endif

endmodule
`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for the gate actuator supervisor with move timeout and retry.
`timescale 1ns / 1ps
module tb_top;
    import gat_pkg::*;

    typedef struct {
        logic [STATES_W-1:0] states;
        logic [IO_GATES-1:0] mask;
        logic [IO_GATES-1:0] toward;
        logic [1:0]          sensed;
    } gate_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [1:0]          command = CMD_SWEEP;
    logic [3:0]          gate_number = 4'd0;
    logic [31:0]         now_ms = 32'd0;
    logic [IO_GATES-1:0] open_switch_levels = '1;
    logic [IO_GATES-1:0] closed_switch_levels = '1;
    logic                result_valid;
    logic [STATES_W-1:0] gate_states;
    logic [IO_GATES-1:0] drive_mask;
    logic [IO_GATES-1:0] drive_toward_open;
    logic [1:0]          sensed_position;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index = CFG_GATE_COUNT;
    logic [15:0]         cfg_data = 16'd0;

    // Predicted per-gate state and register copies.
    gate_mode_t   mode_q [NUM_GATES];
    logic [31:0]  started_at [NUM_GATES];
    logic [1:0]   retries [NUM_GATES];
    logic [3:0]   cfg_gate_count;
    logic [15:0]  cfg_timeout;
    logic [1:0]   cfg_retry_limit;

    gate_result_t pending_results [$];
    int           fail_count = 0;
    bit           gaps_on = 1'b1;
    logic [31:0]  clock_ms = 32'd0;

    gate_actuator_timeout_retry_fsm dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .start                (start),
        .busy                 (busy),
        .command              (command),
        .gate_number          (gate_number),
        .now_ms               (now_ms),
        .open_switch_levels   (open_switch_levels),
        .closed_switch_levels (closed_switch_levels),
        .result_valid         (result_valid),
        .gate_states          (gate_states),
        .drive_mask           (drive_mask),
        .drive_toward_open    (drive_toward_open),
        .sensed_position      (sensed_position),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_failure(input string msg);
        begin
            if (fail_count < 40)
                $display("ERROR at %0t ns: %s", $time, msg);
            fail_count++;
        end
    endtask

    task automatic reset_gate_model();
        int i;
        begin
            cfg_gate_count = GATE_COUNT_RESET;
            cfg_timeout = MOVE_TIMEOUT_RESET;
            cfg_retry_limit = RETRY_LIMIT_RESET;
            for (i = 0; i < NUM_GATES; i++)
            begin
                mode_q[i] = MODE_CLOSED;
                started_at[i] = 32'd0;
                retries[i] = 2'd0;
            end
        end
    endtask

    // Applies one command to the predicted gate state and returns the expected result.
    task automatic apply_gate_command(input cmd_t op, input logic [3:0] num,
                                      input logic [31:0] now,
                                      input logic [IO_GATES-1:0] ol,
                                      input logic [IO_GATES-1:0] cl,
                                      output gate_result_t r);
        int          active;
        int          g;
        int          i;
        logic        in_range;
        logic [31:0] elapsed;
        begin
            active = (cfg_gate_count < NUM_GATES) ? int'(cfg_gate_count) : NUM_GATES;
            in_range = (num >= 1) && (int'(num) <= active);
            g = in_range ? int'(num) - 1 : 0;
            r.mask = '0;
            r.toward = '0;
            r.sensed = SENSE_UNKNOWN;
            case (op)
                CMD_SWEEP:
                begin
                    for (i = 0; i < active; i++)
                    begin
                        if (mode_q[i] == MODE_OPENING || mode_q[i] == MODE_CLOSING)
                        begin
                            elapsed = now - started_at[i];
                            if (elapsed > {16'd0, cfg_timeout})
                            begin
                                if (retries[i] < cfg_retry_limit)
                                begin
                                    retries[i] = retries[i] + 2'd1;
                                    started_at[i] = now;
                                    if (i < IO_GATES)
                                    begin
                                        r.mask[i] = 1'b1;
                                        r.toward[i] = (mode_q[i] == MODE_OPENING);
                                    end
                                end
                                else
                                    mode_q[i] = MODE_ERROR;
                            end
                            else if (mode_q[i] == MODE_OPENING)
                            begin
                                if (i < IO_GATES && !ol[i])
                                    mode_q[i] = MODE_OPEN;
                            end
                            else if (i < IO_GATES && !cl[i])
                                mode_q[i] = MODE_CLOSED;
                        end
                    end
                end
                CMD_OPEN:
                begin
                    if (in_range && (mode_q[g] == MODE_CLOSED || mode_q[g] == MODE_ERROR))
                    begin
                        mode_q[g] = MODE_OPENING;
                        started_at[g] = now;
                        retries[g] = 2'd0;
                        if (g < IO_GATES)
                        begin
                            r.mask[g] = 1'b1;
                            r.toward[g] = 1'b1;
                        end
                    end
                end
                CMD_CLOSE:
                begin
                    if (in_range && (mode_q[g] == MODE_OPEN || mode_q[g] == MODE_ERROR))
                    begin
                        mode_q[g] = MODE_CLOSING;
                        started_at[g] = now;
                        retries[g] = 2'd0;
                        if (g < IO_GATES)
                            r.mask[g] = 1'b1;
                    end
                end
                default:
                begin
                    if (in_range && g < IO_GATES)
                    begin
                        if (!ol[g])
                            r.sensed = SENSE_OPEN;
                        else if (!cl[g])
                            r.sensed = SENSE_CLOSED;
                    end
                end
            endcase
            for (i = 0; i < IO_GATES; i++)
                r.states[3*i +: 3] = mode_q[i];
        end
    endtask

    // Sends one item, with an occasional idle gap in front of it.
    task automatic send_item(input cmd_t op, input logic [3:0] num, input logic [31:0] now,
                             input logic [IO_GATES-1:0] ol, input logic [IO_GATES-1:0] cl);
        gate_result_t r;
        begin
            if (gaps_on && $urandom_range(0, 99) < 34)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            start <= 1'b1;
            command <= op;
            gate_number <= num;
            now_ms <= now;
            open_switch_levels <= ol;
            closed_switch_levels <= cl;
            do
                @(posedge clk);
            while (busy);
            apply_gate_command(op, num, now, ol, cl, r);
            pending_results.push_back(r);
        end
    endtask

    // Lowers start and waits until every predicted result has come back.
    task automatic wait_for_results();
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while (pending_results.size() != 0);
            repeat (16) @(posedge clk);
        end
    endtask

    task automatic write_register(input cfg_idx_t idx, input logic [15:0] data);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= data;
            do
                @(posedge clk);
            while (!cfg_ready);
            case (idx)
                CFG_GATE_COUNT:   cfg_gate_count = data[3:0];
                CFG_MOVE_TIMEOUT: cfg_timeout = data;
                default:          cfg_retry_limit = data[1:0];
            endcase
            cfg_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic set_registers(input logic [3:0] count, input logic [15:0] timeout_ms,
                                 input logic [1:0] limit);
        logic [15:0] junk;
        begin
            junk = 16'($urandom());
            // Upper bits of narrow registers are sometimes set; they must be dropped.
            if ($urandom_range(0, 3) != 0)
                junk = 16'd0;
            write_register(CFG_GATE_COUNT, {junk[15:4], count});
            write_register(CFG_MOVE_TIMEOUT, timeout_ms);
            write_register(CFG_RETRY_LIMIT, {junk[15:2], limit});
        end
    endtask

    // Checks every result strobe against the oldest prediction.
    always @(posedge clk)
    begin
        gate_result_t want;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
                report_failure("result strobe with no item outstanding");
            else
            begin
                want = pending_results.pop_front();
                if (gate_states !== want.states)
                    report_failure($sformatf("gate_states %h, expected %h",
                                             gate_states, want.states));
                if (drive_mask !== want.mask)
                    report_failure($sformatf("drive_mask %h, expected %h",
                                             drive_mask, want.mask));
                if (drive_toward_open !== want.toward)
                    report_failure($sformatf("drive_toward_open %h, expected %h",
                                             drive_toward_open, want.toward));
                if (sensed_position !== want.sensed)
                    report_failure($sformatf("sensed_position %0d, expected %0d",
                                             sensed_position, want.sensed));
            end
        end
    end

    // Queries, opens, closes, timeouts with retries into error, and time wrap.
    task automatic test_reset_defaults();
        begin
            send_item(CMD_QUERY, 4'd0, 32'd0, '0, '0);
            send_item(CMD_QUERY, 4'd11, 32'd0, '0, '0);
            send_item(CMD_QUERY, 4'd1, 32'd0, '0, '0);
            send_item(CMD_QUERY, 4'd10, 32'd0, '1, 10'h1FF);
            send_item(CMD_QUERY, 4'd5, 32'd0, '1, '1);
            send_item(CMD_CLOSE, 4'd1, 32'd50, '1, '1);
            send_item(CMD_OPEN, 4'd1, 32'd100, '1, '1);
            send_item(CMD_OPEN, 4'd10, 32'd100, '1, '1);
            send_item(CMD_OPEN, 4'd1, 32'd150, '1, '1);
            send_item(CMD_SWEEP, 4'd0, 32'd5000, 10'h3FE, '1);
            // Elapsed equal to the timeout is not yet a timeout.
            send_item(CMD_SWEEP, 4'd0, 32'd10100, '1, '1);
            send_item(CMD_SWEEP, 4'd0, 32'd10101, '1, '1);
            send_item(CMD_SWEEP, 4'd0, 32'd20102, '1, '1);
            send_item(CMD_SWEEP, 4'd0, 32'd30103, '1, '1);
            send_item(CMD_SWEEP, 4'd0, 32'd40104, '1, '1);
            send_item(CMD_CLOSE, 4'd1, 32'd40200, '1, '1);
            send_item(CMD_CLOSE, 4'd10, 32'd40200, '1, '1);
            send_item(CMD_SWEEP, 4'd0, 32'd40300, '1, 10'h3FE);
            send_item(CMD_OPEN, 4'd10, 32'd40400, '1, '1);
            send_item(CMD_OPEN, 4'd2, 32'hFFFF_FFF0, '1, '1);
            send_item(CMD_SWEEP, 4'd0, 32'd5, '1, 10'h3FD);
            send_item(CMD_SWEEP, 4'd0, 32'd8, 10'h3FD, '1);
            send_item(CMD_SWEEP, 4'd0, 32'hFFFF_FFFF, '1, '1);
            wait_for_results();
        end
    endtask

    // Register extremes: no active gates, count above the gate total, zero and
    // maximum timeout, and no retries at all.
    task automatic test_register_extremes();
        begin
            set_registers(4'd0, 16'd10000, 2'd3);
            send_item(CMD_OPEN, 4'd1, 32'd500, '1, '1);
            send_item(CMD_QUERY, 4'd1, 32'd500, '0, '0);
            send_item(CMD_SWEEP, 4'd0, 32'd900000, '0, '0);
            wait_for_results();
            set_registers(4'd15, 16'd0, 2'd0);
            send_item(CMD_QUERY, 4'd15, 32'd600, '0, '0);
            send_item(CMD_OPEN, 4'd11, 32'd600, '1, '1);
            send_item(CMD_OPEN, 4'd4, 32'd1000, '1, '1);
            send_item(CMD_SWEEP, 4'd0, 32'd1000, '1, '1);
            send_item(CMD_SWEEP, 4'd0, 32'd1001, '1, '1);
            wait_for_results();
            set_registers(4'd15, 16'd65535, 2'd0);
            send_item(CMD_OPEN, 4'd4, 32'd2000, '1, '1);
            send_item(CMD_SWEEP, 4'd0, 32'd67535, '1, '1);
            send_item(CMD_SWEEP, 4'd0, 32'd67536, '1, '1);
            wait_for_results();
        end
    endtask

    // One random item: mostly small time steps, some near the timeout edge,
    // a few large jumps and occasional wrap of the millisecond counter.
    task automatic send_random_item();
        cmd_t                op;
        logic [3:0]          num;
        logic [31:0]         step;
        logic [IO_GATES-1:0] ol;
        logic [IO_GATES-1:0] cl;
        int                  active;
        int                  pick;
        int                  b;
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                op = CMD_SWEEP;
            else if (pick < 60)
                op = CMD_OPEN;
            else if (pick < 80)
                op = CMD_CLOSE;
            else
                op = CMD_QUERY;
            active = (cfg_gate_count < NUM_GATES) ? int'(cfg_gate_count) : NUM_GATES;
            if (active == 0 || $urandom_range(0, 9) == 0)
                num = 4'($urandom_range(0, 15));
            else
                num = 4'($urandom_range(1, active));
            pick = $urandom_range(0, 99);
            if (pick < 55)
                step = $urandom_range(0, int'(cfg_timeout) / 3);
            else if (pick < 75)
                step = {16'd0, cfg_timeout} + $urandom_range(0, 2) - 1;
            else if (pick < 95)
                step = $urandom_range(0, 3 * int'(cfg_timeout) + 3);
            else
                step = $urandom();
            clock_ms = clock_ms + step;
            if ($urandom_range(0, 99) == 0)
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, int'(cfg_timeout));
            if ($urandom_range(0, 9) == 0)
            begin
                ol = IO_GATES'($urandom());
                cl = IO_GATES'($urandom());
            end
            else
            begin
                ol = '1;
                cl = '1;
                for (b = 0; b < IO_GATES; b++)
                begin
                    if ($urandom_range(0, 99) < 12)
                        ol[b] = 1'b0;
                    if ($urandom_range(0, 99) < 12)
                        cl[b] = 1'b0;
                end
            end
            send_item(op, num, clock_ms, ol, cl);
        end
    endtask

    // The sender holds off until everything outstanding has drained, then resumes.
    task automatic test_drain_pause();
        int k;
        begin
            set_registers(4'd10, 16'd40, 2'd2);
            for (k = 0; k < 30; k++)
            begin
                send_random_item();
                if (k % 10 == 9)
                begin
                    wait_for_results();
                    repeat ($urandom_range(1, 20)) @(posedge clk);
                end
            end
            wait_for_results();
        end
    endtask

    // Random phases, each under its own register setting.
    task automatic test_random_phases();
        int          p;
        int          k;
        logic [3:0]  count;
        logic [15:0] timeout_ms;
        logic [1:0]  limit;
        begin
            for (p = 0; p < 12; p++)
            begin
                case (p)
                    0: begin count = 4'd10; timeout_ms = 16'd10000; limit = 2'd3; end
                    1: begin count = 4'd0;  timeout_ms = 16'd100;   limit = 2'd2; end
                    2: begin count = 4'd15; timeout_ms = 16'd65535; limit = 2'd3; end
                    3: begin count = 4'd5;  timeout_ms = 16'd0;     limit = 2'd0; end
                    4: begin count = 4'd10; timeout_ms = 16'd1;     limit = 2'd1; end
                    5: begin count = 4'd3;  timeout_ms = 16'd50;    limit = 2'd2; end
                    6: begin count = 4'd1;  timeout_ms = 16'd20;    limit = 2'd3; end
                    default:
                    begin
                        count = 4'($urandom_range(1, 15));
                        if ($urandom_range(0, 1) == 0)
                            timeout_ms = 16'($urandom_range(0, 200));
                        else
                            timeout_ms = 16'($urandom());
                        limit = 2'($urandom());
                    end
                endcase
                set_registers(count, timeout_ms, limit);
                // One phase runs with no sender gaps at all.
                gaps_on = (p != 2);
                for (k = 0; k < ((p == 1) ? 40 : 145); k++)
                    send_random_item();
                wait_for_results();
            end
            gaps_on = 1'b1;
        end
    endtask

    initial
    begin
        reset_gate_model();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_register_extremes();
        test_drain_pause();
        test_random_phases();
        wait_for_results();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* gate_actuator_timeout_retry_fsm.f */
rtl/gat_pkg.sv
rtl/gat_ctrl.sv
rtl/gat_datapath.sv
rtl/gate_actuator_timeout_retry_fsm.sv
verif/tb_top.sv
